### src/debug_packet_deframer_defines.svh
// Assertion helpers for the packet deframer.
`ifndef DEBUG_PACKET_DEFRAMER_DEFINES_SVH
`define DEBUG_PACKET_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### src/dpd_pkg.sv
package dpd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIGIT_W = 5;

  localparam logic [BYTE_W-1:0]  CH_START = 8'h24;
  localparam logic [BYTE_W-1:0]  CH_END   = 8'h23;
  localparam logic [COUNT_W-1:0] CNT_MAX  = 16'hffff;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic [COUNT_W-1:0] payload_length;
    logic [BYTE_W-1:0]  computed_sum;
  } result_t;

  // Hex value in the low four bits; bit 4 set when the character is not a hex digit.
  function automatic logic [DIGIT_W-1:0] hex_value(input logic [BYTE_W-1:0] ch);
    logic [BYTE_W-1:0] low;
    logic [BYTE_W-1:0] diff;
    low = ch | 8'h20;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      diff = ch - 8'h30;
      return {1'b0, diff[3:0]};
    end else if (low >= 8'h61 && low <= 8'h66) begin
      diff = low - 8'h57;
      return {1'b0, diff[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

### src/dpd_channels.sv
interface dpd_rx_if;
  logic                         valid;
  logic                         ready;
  logic [dpd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpd_res_if;
  logic                         valid;
  logic                         ready;
  logic [dpd_pkg::KIND_W-1:0]   result_kind;
  logic [dpd_pkg::BYTE_W-1:0]   payload_byte;
  logic [dpd_pkg::COUNT_W-1:0]  payload_length;
  logic [dpd_pkg::BYTE_W-1:0]   computed_sum;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_length, output computed_sum, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input payload_length, input computed_sum, output ready);
endinterface

### src/debug_packet_deframer.sv
// Channel | Direction | Contents
// rx      | in        | rx_byte, one received character
// res     | out       | result_kind, payload_byte, payload_length, computed_sum
//
// One character is taken per cycle while rx.ready is high; a result is registered when its character is taken.
// Each character passes through a single combinational step on the frame state.
// A two-entry output stage (result register plus skid register) keeps rx.ready
// high while one result waits; rx.ready drops only when both entries are full.
// rst is synchronous and returns the block to hunting for '$' with no results held.
`include "debug_packet_deframer_defines.svh"

module debug_packet_deframer (
  input logic       clk,
  input logic       rst,
  dpd_rx_if.sink    rx,
  dpd_res_if.source res
);
  import dpd_pkg::*;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [DIGIT_W-1:0] first_digit, first_digit_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;

  result_t            res_next;
  logic               has_res;
  logic [DIGIT_W-1:0] digit;
  logic               good;

  result_t            out_data, skid_data;
  logic               out_valid, skid_valid;

  logic               accept;
  logic               push;
  logic               pop;

  assign rx.ready = !skid_valid;
  assign accept   = rx.valid && rx.ready;
  assign push     = accept && has_res;
  assign pop      = out_valid && res.ready;

  assign digit = hex_value(rx.rx_byte);
  assign good  = !first_digit[4] && !digit[4] &&
                 ({first_digit[3:0], digit[3:0]} == running_sum);

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    first_digit_next = first_digit;
    byte_count_next  = byte_count;
    has_res          = 1'b0;
    res_next         = '0;
    unique case (phase)
      PH_HUNT: begin
        if (rx.rx_byte == CH_START) begin
          running_sum_next = '0;
          byte_count_next  = '0;
          first_digit_next = '0;
          phase_next       = PH_DATA;
        end
      end
      PH_DATA: begin
        if (rx.rx_byte == CH_END) begin
          phase_next = PH_DIG1;
        end else begin
          running_sum_next      = running_sum + rx.rx_byte;
          byte_count_next       = (byte_count == CNT_MAX) ? byte_count : byte_count + 1'b1;
          has_res               = 1'b1;
          res_next.result_kind  = KIND_BYTE;
          res_next.payload_byte = rx.rx_byte;
        end
      end
      PH_DIG1: begin
        first_digit_next = digit;
        phase_next       = PH_DIG2;
      end
      PH_DIG2: begin
        has_res                 = 1'b1;
        res_next.result_kind    = good ? KIND_GOOD : KIND_BAD;
        res_next.payload_length = byte_count;
        res_next.computed_sum   = running_sum;
        phase_next              = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= '0;
      first_digit <= '0;
      byte_count  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      first_digit <= first_digit_next;
      byte_count  <= byte_count_next;
    end
  end

  // The skid entry is only filled when the result register is held by a stalled transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid          = out_valid;
  assign res.result_kind    = out_data.result_kind;
  assign res.payload_byte   = out_data.payload_byte;
  assign res.payload_length = out_data.payload_length;
  assign res.computed_sum   = out_data.computed_sum;

  `DPD_ASSERT_SAME(a_skid_needs_out, skid_valid, out_valid)
  `DPD_ASSERT_NEXT(a_payload_lands, accept && phase == PH_DATA && rx.rx_byte != CH_END, out_valid)
  `DPD_ASSERT_NEXT(a_verdict_rehunts, accept && phase == PH_DIG2, phase == PH_HUNT)
  `DPD_ASSERT_NEXT(a_count_saturates, byte_count == CNT_MAX && phase == PH_DATA,
                   byte_count == CNT_MAX)

endmodule

### test/tb_debug_packet_deframer.sv
module tb_debug_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import dpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_500_000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned RANDOM_ITEMS   = 1220;
  localparam int unsigned MAX_REPORTS    = 40;

  localparam int unsigned CKS_GOOD   = 0;
  localparam int unsigned CKS_WRONG  = 1;
  localparam int unsigned CKS_GARBLE = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpd_rx_if  rx();
  dpd_res_if res();

  debug_packet_deframer u_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res)
  );

  always #10 clk = ~clk;

  logic [BYTE_W-1:0] char_q[$];
  result_t           expected_q[$];
  int unsigned       err_count   = 0;
  int unsigned       cycle_count = 0;
  bit                long_hold_req = 1'b0;

  // Frame tracking state of the predictor.
  phase_t             frame_phase  = PH_HUNT;
  logic [BYTE_W-1:0]  frame_sum    = '0;
  logic [DIGIT_W-1:0] first_nibble = '0;
  logic [COUNT_W-1:0] frame_len    = '0;

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") begin
      return {1'b0, 4'(c - "0")};
    end
    if (folded >= "a" && folded <= "f") begin
      return {1'b0, 4'(folded - "a" + 8'd10)};
    end
    return 5'h10;
  endfunction

  function automatic void frame_step(input logic [BYTE_W-1:0] c, output bit has_res,
                                     output result_t out_item);
    logic [DIGIT_W-1:0] second;
    has_res  = 1'b0;
    out_item = '0;
    case (frame_phase)
      PH_HUNT: begin
        if (c == CH_START) begin
          frame_sum    = '0;
          frame_len    = '0;
          first_nibble = '0;
          frame_phase  = PH_DATA;
        end
      end
      PH_DATA: begin
        if (c == CH_END) begin
          frame_phase = PH_DIG1;
        end else begin
          frame_sum = frame_sum + c;
          if (frame_len != CNT_MAX) frame_len = frame_len + 1'b1;
          has_res = 1'b1;
          out_item.result_kind  = KIND_BYTE;
          out_item.payload_byte = c;
        end
      end
      PH_DIG1: begin
        first_nibble = digit_value(c);
        frame_phase  = PH_DIG2;
      end
      default: begin
        second  = digit_value(c);
        has_res = 1'b1;
        if (!first_nibble[4] && !second[4] &&
            {first_nibble[3:0], second[3:0]} == frame_sum) begin
          out_item.result_kind = KIND_GOOD;
        end else begin
          out_item.result_kind = KIND_BAD;
        end
        out_item.payload_length = frame_len;
        out_item.computed_sum   = frame_sum;
        frame_phase = PH_HUNT;
      end
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch without any.
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sender side.
  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;

  always @(posedge clk) begin
    bit      got_res;
    result_t item;
    if (rst) begin
      rx.valid <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        frame_step(rx.rx_byte, got_res, item);
        if (got_res) expected_q.push_back(item);
      end
      if (!rx.valid || rx.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          rx.valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          rx.rx_byte <= char_q.pop_front();
          rx.valid   <= 1'b1;
          tx_gap = next_gap(tx_calm);
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side.
  int unsigned rx_hold   = 0;
  int unsigned rx_calm   = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", COUNT_W'(res.result_kind), '0);
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", COUNT_W'(res.result_kind), COUNT_W'(want.result_kind));
          check_field("payload_byte", COUNT_W'(res.payload_byte),
                      COUNT_W'(want.payload_byte));
          check_field("payload_length", res.payload_length, want.payload_length);
          check_field("computed_sum", COUNT_W'(res.computed_sum),
                      COUNT_W'(want.computed_sum));
        end
      end
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        rx_hold   = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        res.ready <= 1'b0;
      end else begin
        rx_hold = next_gap(rx_calm);
        res.ready <= (rx_hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 10) return "0" + nib;
    return (upper ? "A" : "a") + nib - 8'd10;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  // Queues one frame; '#' never appears in the payload since it would end it early.
  task automatic push_frame(input int unsigned len, input int unsigned cks_style);
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] cks;
    sum = '0;
    char_q.push_back(CH_START);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        c = CH_START;
      end else begin
        do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_END);
      end
      sum = sum + c;
      char_q.push_back(c);
    end
    char_q.push_back(CH_END);
    if (cks_style == CKS_GARBLE) begin
      char_q.push_back(BYTE_W'($urandom_range(0, 255)));
      char_q.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      cks = sum;
      if (cks_style == CKS_WRONG) cks = sum ^ 8'($urandom_range(1, 255));
      char_q.push_back(hex_char(cks[7:4], 1'($urandom_range(0, 1))));
      char_q.push_back(hex_char(cks[3:0], 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || rx.valid) @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned counted;
    int unsigned r;
    int unsigned len;
    int unsigned style;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    res.ready  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Stray acknowledgements and extremes while hunting, then an empty frame,
    // a payload holding '$' and both byte extremes, upper-case digits, and
    // invalid characters in either checksum position.
    push_text("+");
    char_q.push_back(8'hff);
    push_text("$#00");
    char_q.push_back(CH_START);
    char_q.push_back(8'hff);
    char_q.push_back(8'h00);
    push_text("$#23");
    push_text("$J#4A");
    push_text("$a#6g");
    push_text("$a#Z1");
    wait_drained();

    // The receiver holds off while short frames keep coming, so the output
    // stage fills and the input must stall.
    @(negedge clk);
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) push_frame($urandom_range(1, 6), CKS_GOOD);
    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        len = $urandom_range(1, 3);
        repeat (len) char_q.push_back(BYTE_W'($urandom_range(0, 255)));
        counted += len;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        if (r < 80) begin
          style = ($urandom_range(0, 9) < 8) ? CKS_GOOD : CKS_WRONG;
        end else begin
          style = ($urandom_range(0, 1) == 0) ? CKS_WRONG : CKS_GARBLE;
        end
        push_frame(len, style);
        counted += len + 4;
      end
      if (char_q.size() > 200) begin
        while (char_q.size() >= 50) @(negedge clk);
      end
    end
    wait_drained();
    repeat (10) @(negedge clk);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### debug_packet_deframer.f
+incdir+src
src/dpd_pkg.sv
src/dpd_channels.sv
src/debug_packet_deframer.sv
test/tb_debug_packet_deframer.sv
